### rtl/tlde_pkg.sv
// Package for the tree LCA / distance engine.
// Holds the field widths, status and command codes, the datapath operation
// codes, the controller states and the datapath status struct.
package tlde_pkg;

  localparam int unsigned NODE_W   = 10;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned DEPTH_W  = 10;
  localparam int unsigned STATUS_W = 2;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_MISSING  = 2'd1,
    STS_ATTACHED = 2'd2
  } status_e;

  typedef enum logic {
    CMD_ATTACH = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  // Operations the controller asks of the datapath in one cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_FETCH,
    OP_CHECK_ERR,
    OP_ATT_START,
    OP_ATT_STEP,
    OP_ATT_LAST,
    OP_Q_START,
    OP_LIFT,
    OP_CLIMB,
    OP_ANC,
    OP_MISS,
    OP_FINISH
  } op_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_CHECK,
    S_ATT,
    S_LIFT,
    S_CLIMB,
    S_ANC,
    S_FINISH
  } state_e;

  // Status flags the datapath reports back to the controller.
  typedef struct packed {
    logic clr_last;
    logic lvl_last;
    logic lvl_zero;
    logic chk_err;
    logic is_query;
    logic meet;
    logic anc_zero;
  } dp_sts_t;

endpackage

### rtl/tlde_dp.sv
// Datapath of the tree LCA / distance engine: ancestor table, depth store,
// attach marks, walk registers and result registers.
// Depends on tlde_pkg; driven one operation per cycle by tlde_ctrl.
module tlde_dp import tlde_pkg::*; #(
  parameter int unsigned MAX_NODES   = 1024,
  parameter int unsigned LIFT_LEVELS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  op_e                 op_i,
  input  cmd_e                cmd_i,
  input  logic [NODE_W-1:0]   node_a_i,
  input  logic [NODE_W-1:0]   node_b_i,
  output dp_sts_t             sts_o,
  output logic [NODE_W-1:0]   res_anc_o,
  output logic [LEN_W-1:0]    res_len_o,
  output logic [DEPTH_W-1:0]  res_dep_o,
  output status_e             res_st_o
);

  localparam int unsigned IDX_W      = $clog2(MAX_NODES);
  localparam int unsigned LVL_W      = $clog2(LIFT_LEVELS);
  localparam int unsigned NODE_SLOTS = 2 ** IDX_W;
  localparam int unsigned TBL_DEPTH  = LIFT_LEVELS * NODE_SLOTS;

  localparam logic [16:0]      MAX_N    = 17'(MAX_NODES);
  localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(MAX_NODES - 1);
  localparam logic [LVL_W-1:0] LVL_TOP  = LVL_W'(LIFT_LEVELS - 1);
  localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);

  // Storage. Node 0 is the sentinel: table reads at node 0 are forced to zero.
  logic [NODE_W-1:0]  tbl_mem  [TBL_DEPTH];
  logic [DEPTH_W-1:0] dep_mem  [NODE_SLOTS];
  logic               mark_mem [NODE_SLOTS];

  logic [NODE_W-1:0]  tbl_rd0_q, tbl_rd1_q;
  logic               tz0_q, tz1_q;
  logic [DEPTH_W-1:0] dep_rd0_q, dep_rd1_q;
  logic               mark_rd0_q, mark_rd1_q;

  // Working registers.
  cmd_e                   cmd_q;
  logic [NODE_W-1:0]      a_q, b_q, lo_q, hi_q, anc_q;
  logic [DEPTH_W-1:0]     da_q, db_q, d_q;
  logic [LIFT_LEVELS-1:0] diff_q;
  logic [LVL_W-1:0]       lvl_q;
  logic [IDX_W-1:0]       clr_cnt_q;

  logic [NODE_W-1:0]  res_anc_q;
  logic [LEN_W-1:0]   res_len_q;
  logic [DEPTH_W-1:0] res_dep_q;
  status_e            res_st_q;

  // Memory port controls.
  logic               tbl_re0, tbl_re1, tbl_we;
  logic [LVL_W-1:0]   tbl_rl0, tbl_rl1, tbl_wl;
  logic [NODE_W-1:0]  tbl_rn0, tbl_rn1, tbl_wd;
  logic               dep_re0, dep_re1, dep_we;
  logic [NODE_W-1:0]  dep_rn0;
  logic [DEPTH_W-1:0] dep_wd;
  logic               mark_re, mark_we, mark_wd;
  logic [IDX_W-1:0]   mark_wa;

  logic [NODE_W-1:0]  t0, t1;
  logic               a_valid, b_valid, a_pres, b_pres, a_deeper;
  status_e            chk_code;
  logic [DEPTH_W-1:0] d_att, diff_full;
  logic [NODE_W-1:0]  lo_init, hi_init, hi_new, lo_c, hi_c;
  logic               lvl_last, lvl_zero;
  logic [DEPTH_W:0]   len_full;

  assign t0 = tz0_q ? '0 : tbl_rd0_q;
  assign t1 = tz1_q ? '0 : tbl_rd1_q;

  assign lvl_last = (lvl_q == LVL_TOP);
  assign lvl_zero = (lvl_q == '0);

  // Presence checks on the captured item.
  assign a_valid = (a_q != '0) && ({7'b0, a_q} < MAX_N);
  assign b_valid = (b_q != '0) && ({7'b0, b_q} < MAX_N);
  assign a_pres  = a_valid && mark_rd0_q;
  assign b_pres  = b_valid && mark_rd1_q;

  always_comb begin
    chk_code = STS_OK;
    if (cmd_q == CMD_QUERY) begin
      if (!(a_pres && b_pres)) chk_code = STS_MISSING;
    end else begin
      priority if (!a_valid)                  chk_code = STS_MISSING;
      else if (mark_rd0_q)                    chk_code = STS_ATTACHED;
      else if ((b_q != '0) && !b_pres)        chk_code = STS_MISSING;
      else                                    chk_code = STS_OK;
    end
  end

  assign d_att = (b_q == '0) ? '0 :
                 (dep_rd1_q == DEPTH_MAX) ? DEPTH_MAX : dep_rd1_q + DEPTH_W'(1);

  assign a_deeper  = (dep_rd0_q > dep_rd1_q);
  assign lo_init   = a_deeper ? b_q : a_q;
  assign hi_init   = a_deeper ? a_q : b_q;
  assign diff_full = a_deeper ? (dep_rd0_q - dep_rd1_q) : (dep_rd1_q - dep_rd0_q);

  assign hi_new = diff_q[lvl_q] ? t1 : hi_q;
  assign lo_c   = (t0 != t1) ? t0 : lo_q;
  assign hi_c   = (t0 != t1) ? t1 : hi_q;

  assign len_full = 11'({1'b0, da_q} + {1'b0, db_q}) - {dep_rd0_q, 1'b0};

  always_comb begin
    tbl_re0 = 1'b0;  tbl_rl0 = '0;  tbl_rn0 = '0;
    tbl_re1 = 1'b0;  tbl_rl1 = '0;  tbl_rn1 = '0;
    tbl_we  = 1'b0;  tbl_wl  = '0;  tbl_wd  = '0;
    dep_re0 = 1'b0;  dep_rn0 = '0;  dep_re1 = 1'b0;
    dep_we  = 1'b0;  dep_wd  = '0;
    mark_re = 1'b0;  mark_we = 1'b0; mark_wa = '0;  mark_wd = 1'b0;
    unique case (op_i)
      OP_CLEAR: begin
        mark_we = 1'b1;
        mark_wa = clr_cnt_q;
      end
      OP_FETCH: begin
        mark_re = 1'b1;
        dep_re0 = 1'b1;
        dep_rn0 = a_q;
        dep_re1 = 1'b1;
      end
      OP_ATT_START: begin
        tbl_we  = 1'b1;
        tbl_wd  = b_q;
        dep_we  = 1'b1;
        dep_wd  = d_att;
        mark_we = 1'b1;
        mark_wa = IDX_W'(a_q);
        mark_wd = 1'b1;
        tbl_re0 = 1'b1;
        tbl_rn0 = b_q;
      end
      OP_ATT_STEP: begin
        tbl_we  = 1'b1;
        tbl_wl  = lvl_q;
        tbl_wd  = t0;
        tbl_re0 = 1'b1;
        tbl_rl0 = lvl_q;
        tbl_rn0 = t0;
      end
      OP_ATT_LAST: begin
        tbl_we = 1'b1;
        tbl_wl = lvl_q;
        tbl_wd = t0;
      end
      OP_Q_START: begin
        tbl_re1 = 1'b1;
        tbl_rn1 = hi_init;
      end
      OP_LIFT: begin
        tbl_re1 = 1'b1;
        tbl_rn1 = hi_new;
        if (lvl_last) begin
          // Set up the first climb step and the depth of the meeting node.
          tbl_re0 = 1'b1;
          tbl_rl0 = LVL_TOP;
          tbl_rn0 = lo_q;
          tbl_rl1 = LVL_TOP;
          dep_re0 = 1'b1;
          dep_rn0 = lo_q;
        end else begin
          tbl_rl1 = lvl_q + LVL_ONE;
        end
      end
      OP_CLIMB: begin
        tbl_re0 = 1'b1;
        tbl_rn0 = lo_c;
        if (!lvl_zero) begin
          tbl_rl0 = lvl_q - LVL_ONE;
          tbl_re1 = 1'b1;
          tbl_rl1 = lvl_q - LVL_ONE;
          tbl_rn1 = hi_c;
        end
      end
      OP_ANC: begin
        dep_re0 = 1'b1;
        dep_rn0 = t0;
      end
      default: begin
      end
    endcase
  end

  // Ancestor table: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[{tbl_wl, IDX_W'(a_q)}] <= tbl_wd;
    if (tbl_re0) begin
      tbl_rd0_q <= tbl_mem[{tbl_rl0, IDX_W'(tbl_rn0)}];
      tz0_q     <= (tbl_rn0 == '0);
    end
    if (tbl_re1) begin
      tbl_rd1_q <= tbl_mem[{tbl_rl1, IDX_W'(tbl_rn1)}];
      tz1_q     <= (tbl_rn1 == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (dep_we)  dep_mem[IDX_W'(a_q)] <= dep_wd;
    if (dep_re0) dep_rd0_q <= dep_mem[IDX_W'(dep_rn0)];
    if (dep_re1) dep_rd1_q <= dep_mem[IDX_W'(b_q)];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (mark_re) begin
      mark_rd0_q <= mark_mem[IDX_W'(a_q)];
      mark_rd1_q <= mark_mem[IDX_W'(b_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      lvl_q     <= '0;
    end else begin
      unique case (op_i)
        OP_CLEAR:     clr_cnt_q <= clr_cnt_q + IDX_W'(1);
        OP_ATT_START: lvl_q <= LVL_ONE;
        OP_ATT_STEP:  lvl_q <= lvl_q + LVL_ONE;
        OP_Q_START:   lvl_q <= '0;
        OP_LIFT:      if (!lvl_last) lvl_q <= lvl_q + LVL_ONE;
        OP_CLIMB:     if (!lvl_zero) lvl_q <= lvl_q - LVL_ONE;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LOAD: begin
        cmd_q <= cmd_i;
        a_q   <= node_a_i;
        b_q   <= node_b_i;
      end
      OP_CHECK_ERR: begin
        res_anc_q <= '0;
        res_len_q <= '0;
        res_dep_q <= '0;
        res_st_q  <= chk_code;
      end
      OP_ATT_START: d_q <= d_att;
      OP_ATT_LAST: begin
        res_anc_q <= '0;
        res_len_q <= '0;
        res_dep_q <= d_q;
        res_st_q  <= STS_OK;
      end
      OP_Q_START: begin
        lo_q   <= lo_init;
        hi_q   <= hi_init;
        diff_q <= LIFT_LEVELS'(diff_full);
        da_q   <= dep_rd0_q;
        db_q   <= dep_rd1_q;
      end
      OP_LIFT: begin
        hi_q <= hi_new;
        if (lvl_last) anc_q <= lo_q;
      end
      OP_CLIMB: begin
        lo_q <= lo_c;
        hi_q <= hi_c;
      end
      OP_ANC: anc_q <= t0;
      OP_MISS: begin
        res_anc_q <= '0;
        res_len_q <= '0;
        res_dep_q <= '0;
        res_st_q  <= STS_MISSING;
      end
      OP_FINISH: begin
        res_anc_q <= anc_q;
        res_len_q <= len_full;
        res_dep_q <= dep_rd0_q;
        res_st_q  <= STS_OK;
      end
      default: begin
      end
    endcase
  end

  assign sts_o.clr_last = (clr_cnt_q == CLR_LAST);
  assign sts_o.lvl_last = lvl_last;
  assign sts_o.lvl_zero = lvl_zero;
  assign sts_o.chk_err  = (chk_code != STS_OK);
  assign sts_o.is_query = (cmd_q == CMD_QUERY);
  assign sts_o.meet     = (lo_q == hi_new);
  assign sts_o.anc_zero = (t0 == '0);

  assign res_anc_o = res_anc_q;
  assign res_len_o = res_len_q;
  assign res_dep_o = res_dep_q;
  assign res_st_o  = res_st_q;

endmodule

### rtl/tlde_ctrl.sv
// Controller of the tree LCA / distance engine: sequences the clearing pass,
// attach and query walks, and owns the input ready and output valid.
// Depends on tlde_pkg; drives tlde_dp through op_o and reads its status.
module tlde_ctrl import tlde_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_valid_i,
  output logic    s_ready_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  input  dp_sts_t sts_i,
  output op_e     op_o
);

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   res_load, out_free;

  assign out_free = !m_valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    op_o      = OP_NONE;
    s_ready_o = 1'b0;
    res_load  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        op_o = OP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          op_o    = OP_LOAD;
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        op_o    = OP_FETCH;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.chk_err) begin
          if (out_free) begin
            op_o     = OP_CHECK_ERR;
            res_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else if (sts_i.is_query) begin
          op_o    = OP_Q_START;
          state_d = S_LIFT;
        end else begin
          op_o    = OP_ATT_START;
          state_d = S_ATT;
        end
      end
      S_ATT: begin
        if (!sts_i.lvl_last) begin
          op_o = OP_ATT_STEP;
        end else if (out_free) begin
          op_o     = OP_ATT_LAST;
          res_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_LIFT: begin
        op_o = OP_LIFT;
        if (sts_i.lvl_last) state_d = sts_i.meet ? S_FINISH : S_CLIMB;
      end
      S_CLIMB: begin
        op_o = OP_CLIMB;
        if (sts_i.lvl_zero) state_d = S_ANC;
      end
      S_ANC: begin
        if (!sts_i.anc_zero) begin
          op_o    = OP_ANC;
          state_d = S_FINISH;
        end else if (out_free) begin
          op_o     = OP_MISS;
          res_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          op_o     = OP_FINISH;
          res_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    priority if (res_load) m_valid_d = 1'b1;
    else if (m_ready_i)    m_valid_d = 1'b0;
    else                   m_valid_d = m_valid_q;
  end

  assign m_valid_o = m_valid_q;

`ifndef NO_ASSERTIONS
  a_res_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!m_valid_q || m_ready_i))
    else $error("result loaded over a result that was not taken");

  a_res_shows_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> m_valid_q)
    else $error("loaded result not presented");

  a_accept_starts_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> (state_q == S_FETCH))
    else $error("accepted item did not start a fetch");
`endif

endmodule

### rtl/tree_lca_distance_engine.sv
// Top level of the tree LCA / distance engine.
// Depends on tlde_pkg, tlde_ctrl (sequencer) and tlde_dp (tables and walks).
//
// Usage. One item enters on the slave stream: tuser carries the command
// (attach or query) and tdata carries node_a and node_b. An attach hangs
// node_a under node_b (node_b zero makes node_a a root) and fills its
// ancestor row one lift level per cycle, the last one once the output
// slot is free. A query lifts the deeper node to the depth of the
// shallower one, one level per cycle, then climbs both nodes from the top
// level down, one level per cycle, to find the lowest common ancestor and
// the path length between the two nodes.
// Exactly one result item leaves on the master stream for every item.
// The item is taken in the idle cycle. The walks are serial over the
// single ancestor table: each level is one table read whose result
// addresses the next read. The next item can be taken in the cycle after
// a result is loaded.
// Reset: the engine first clears the attach marks of all MAX_NODES nodes,
// one node per cycle; tready stays low during that pass.
// Stall: a finished result waits in the output register; the engine takes
// the next item meanwhile and holds its own result until the slot is free.
module tree_lca_distance_engine import tlde_pkg::*; #(
  parameter int unsigned MAX_NODES   = 1024,
  parameter int unsigned LIFT_LEVELS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // [9:0] node_a, [19:10] node_b, [23:20] zero
  input  logic        s_axis_tuser_i,  // [0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o   // [9:0] ancestor_node, [20:10] path_length,
                                       // [30:21] node_depth, [32:31] status,
                                       // [39:33] zero
);

  op_e                op;
  dp_sts_t            dp_sts;
  logic [NODE_W-1:0]  res_anc;
  logic [LEN_W-1:0]   res_len;
  logic [DEPTH_W-1:0] res_dep;
  status_e            res_st;

  // The controller owns both handshakes; the datapath never sees them.
  tlde_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (dp_sts),
    .op_o      (op)
  );

  // The datapath captures the item on the load operation and holds the
  // result fields stable until the next result is loaded.
  tlde_dp #(
    .MAX_NODES   (MAX_NODES),
    .LIFT_LEVELS (LIFT_LEVELS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op),
    .cmd_i     (cmd_e'(s_axis_tuser_i)),
    .node_a_i  (s_axis_tdata_i[9:0]),
    .node_b_i  (s_axis_tdata_i[19:10]),
    .sts_o     (dp_sts),
    .res_anc_o (res_anc),
    .res_len_o (res_len),
    .res_dep_o (res_dep),
    .res_st_o  (res_st)
  );

  assign m_axis_tdata_o = {7'b0, res_st, res_dep, res_len, res_anc};

endmodule
